// ===== hdl/pltm_pkg.sv =====
// Shared types and constants for the piecewise-linear time map.
// Used by piecewise_linear_time_map and pltm_divider; no dependencies.
package pltm_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int CNT_W          = 5;                // point_count register
    localparam int IDX_W          = 4;                // point_index field
    localparam int SEC_W          = 17;               // seconds fields
    localparam int MS_W           = 29;               // millisecond fields
    localparam int KSEC_W         = 27;               // seconds * 1000
    localparam int DT_W           = MS_W + 1;         // signed time offset
    localparam int DS_W           = SEC_W + 1;        // signed second deltas
    localparam int PROD_W         = 48;               // offset * target delta
    localparam int DIV_W          = PROD_W;           // dividend magnitude
    localparam int QUO_W          = DIV_W + 1;        // signed quotient
    localparam int SUM_W          = QUO_W + 1;        // signed mapped sum
    localparam int DIV_BITS       = 2;                // quotient bits per cycle
    localparam int DIV_ITER       = DIV_W / DIV_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_ITER);
    localparam int MS_PER_S       = 1000;
    localparam int MAPPED_MAX     = 359999999;
    localparam int STATUS_W       = 2;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_MAP   = 1'b1
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_LOW        = 2'd1,
        STATUS_HIGH       = 2'd2,
        STATUS_ZERO_WIDTH = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH0,
        ST_WALK,
        ST_SETUP,
        ST_START,
        ST_DIVIDE,
        ST_FIXUP,
        ST_FINISH
    } state_t;

endpackage

// ===== hdl/pltm_divider.sv =====
// Unsigned restoring divider, DIV_BITS quotient bits per cycle.
// Depends on pltm_pkg for widths; divisor must be nonzero.
module pltm_divider
    import pltm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [SEC_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient,
    output logic             rem_nz
);

    logic [SEC_W:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [SEC_W-1:0]   div_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    always_comb begin
        logic [SEC_W:0]   r;
        logic [DIV_W-1:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int k = 0; k < DIV_BITS; k++) begin
            r = {r[SEC_W-1:0], q[DIV_W-1]};
            q = {q[DIV_W-2:0], 1'b0};
            if (r >= {1'b0, div_reg}) begin
                r    = r - {1'b0, div_reg};
                q[0] = 1'b1;
            end
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_ITER - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_nz   = (rem_reg != '0);

endmodule

// ===== hdl/piecewise_linear_time_map.sv =====
// Piecewise-linear time map: breakpoint table in a synchronous memory,
// sequential segment search and floored interpolation. Uses pltm_pkg, pltm_divider.
//
//  channel | direction | words
//  s_*     | in        | breakpoint write or time stamp to map
//  m_*     | out       | mapped_ms and status, one word per map request
//  cfg_*   | in        | point_count, always ready
//
// A breakpoint write is stored on accept. A map request walks the table one entry
// per cycle through the memory read port, then runs the 2-bit-per-cycle divider;
// the chosen segment ends at index 1..count-1; a zero-width segment skips the divider.
// One item at a time; the output register lets the next word in while a result
// waits. Reset clears control only; the table reads as undefined until written.
module piecewise_linear_time_map
    import pltm_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_req_type,
    input  logic [IDX_W-1:0] s_point_index,
    input  logic [SEC_W-1:0] s_source_seconds,
    input  logic [SEC_W-1:0] s_target_seconds,
    input  logic [MS_W-1:0]  s_time_ms,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [MS_W-1:0]  m_mapped_ms,
    output logic [STATUS_W-1:0] m_status,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_point_count
);

    localparam int IW    = $clog2(MAX_POINTS);
    localparam int ENT_W = 2 * SEC_W;

    state_t state_reg, state_next;

    logic [ENT_W-1:0] bp_mem [MAX_POINTS];
    logic [ENT_W-1:0] rd_data_reg;
    logic [IW-1:0]    rd_addr;
    logic             wr_en;

    logic [CNT_W-1:0] point_count_reg;
    logic [MS_W-1:0]  t_reg, t_next;
    logic [IW-1:0]    cnt_m1_reg, cnt_m1_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [ENT_W-1:0] prev_reg, prev_next;
    logic [ENT_W-1:0] cur_reg, cur_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [SEC_W-1:0] dxa_reg, dxa_next;
    logic             neg_reg, neg_next;
    logic             zw_reg, zw_next;
    logic [KSEC_W-1:0] y1k_reg, y1k_next;
    logic signed [QUO_W-1:0] q_reg, q_next;

    logic             m_valid_reg, m_valid_next;
    logic [MS_W-1:0]  mapped_reg, mapped_next;
    status_t          status_reg, status_next;

    logic             accept;
    logic             out_free;
    logic [KSEC_W-1:0] rd_src_k;
    logic [KSEC_W-1:0] x1k;
    logic signed [DT_W-1:0] dt;
    logic signed [DS_W-1:0] dx, dy;
    logic [DIV_W-1:0] div_dividend;
    logic             div_start, div_done, div_rem_nz;
    logic [DIV_W-1:0] div_quo;
    logic signed [SUM_W-1:0] sum;

    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    // breakpoint entry: {source, target}
    assign rd_src_k = KSEC_W'(rd_data_reg[ENT_W-1:SEC_W]) * KSEC_W'(MS_PER_S);
    assign x1k      = KSEC_W'(prev_reg[ENT_W-1:SEC_W]) * KSEC_W'(MS_PER_S);
    assign dt       = $signed({1'b0, t_reg}) - $signed({(DT_W-KSEC_W)'(0), x1k});
    assign dx       = $signed({1'b0, cur_reg[ENT_W-1:SEC_W]})
                    - $signed({1'b0, prev_reg[ENT_W-1:SEC_W]});
    assign dy       = $signed({1'b0, cur_reg[SEC_W-1:0]})
                    - $signed({1'b0, prev_reg[SEC_W-1:0]});
    assign div_dividend = prod_reg[PROD_W-1] ? DIV_W'(-prod_reg) : DIV_W'(prod_reg);
    assign sum      = SUM_W'($signed({1'b0, y1k_reg})) + SUM_W'(q_reg);

    assign wr_en = accept && (s_req_type == REQ_WRITE) && (32'(s_point_index) < MAX_POINTS);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            bp_mem[IW'(s_point_index)] <= {s_source_seconds, s_target_seconds};
        end
        rd_data_reg <= bp_mem[rd_addr];
    end

    pltm_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dxa_reg),
        .done     (div_done),
        .quotient (div_quo),
        .rem_nz   (div_rem_nz)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            point_count_reg <= CNT_W'(2);
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                point_count_reg <= cfg_point_count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        t_reg      <= t_next;
        cnt_m1_reg <= cnt_m1_next;
        idx_reg    <= idx_next;
        prev_reg   <= prev_next;
        cur_reg    <= cur_next;
        prod_reg   <= prod_next;
        dxa_reg    <= dxa_next;
        neg_reg    <= neg_next;
        zw_reg     <= zw_next;
        y1k_reg    <= y1k_next;
        q_reg      <= q_next;
        mapped_reg <= mapped_next;
        status_reg <= status_next;
    end

    always_comb begin
        int cnt_i;
        logic signed [QUO_W-1:0] qs;
        cnt_i        = int'(point_count_reg);
        qs           = $signed({1'b0, div_quo});
        state_next   = state_reg;
        t_next       = t_reg;
        cnt_m1_next  = cnt_m1_reg;
        idx_next     = idx_reg;
        prev_next    = prev_reg;
        cur_next     = cur_reg;
        prod_next    = prod_reg;
        dxa_next     = dxa_reg;
        neg_next     = neg_reg;
        zw_next      = zw_reg;
        y1k_next     = y1k_reg;
        q_next       = q_reg;
        mapped_next  = mapped_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        rd_addr      = '0;
        div_start    = 1'b0;

        if (cnt_i < 2) begin
            cnt_i = 2;
        end
        if (cnt_i > MAX_POINTS) begin
            cnt_i = MAX_POINTS;
        end

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_req_type == REQ_MAP) begin
                    t_next      = s_time_ms;
                    cnt_m1_next = IW'(cnt_i - 1);
                    idx_next    = IW'(1);
                    state_next  = ST_FETCH0;
                end
            end
            ST_FETCH0: begin
                // entry 0 arrives; request entry 1
                prev_next  = rd_data_reg;
                rd_addr    = idx_reg;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                rd_addr = idx_reg + 1'b1;
                if (idx_reg == cnt_m1_reg || MS_W'(rd_src_k) >= t_reg) begin
                    cur_next   = rd_data_reg;
                    state_next = ST_SETUP;
                end else begin
                    prev_next = rd_data_reg;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            ST_SETUP: begin
                prod_next = PROD_W'(dt) * PROD_W'(dy);
                dxa_next  = dx[DS_W-1] ? SEC_W'(-dx) : SEC_W'(dx);
                neg_next  = dt[DT_W-1] ^ dy[DS_W-1] ^ dx[DS_W-1];
                y1k_next  = KSEC_W'(prev_reg[SEC_W-1:0]) * KSEC_W'(MS_PER_S);
                zw_next   = (dx == '0);
                state_next = (dx == '0) ? ST_FINISH : ST_START;
            end
            ST_START: begin
                div_start  = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    state_next = ST_FIXUP;
                end
            end
            ST_FIXUP: begin
                // floor: round a negative inexact quotient down
                if (neg_reg && prod_reg != '0) begin
                    q_next = -qs - $signed(QUO_W'(div_rem_nz));
                end else begin
                    q_next = qs;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (zw_reg) begin
                        mapped_next = '0;
                        status_next = STATUS_ZERO_WIDTH;
                    end else if (sum < 0) begin
                        mapped_next = '0;
                        status_next = STATUS_LOW;
                    end else if (sum > SUM_W'(MAPPED_MAX)) begin
                        mapped_next = MS_W'(MAPPED_MAX);
                        status_next = STATUS_HIGH;
                    end else begin
                        mapped_next = sum[MS_W-1:0];
                        status_next = STATUS_OK;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_mapped_ms = mapped_reg;
    assign m_status    = status_reg;

endmodule

// ===== sim/pltm_map_check.sv =====
// Channel monitor for piecewise_linear_time_map: mirrors the breakpoint table and
// point_count, predicts every mapped word and compares it. Depends on pltm_pkg.
`timescale 1ns / 1ps

module pltm_map_check
    import pltm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic                s_req_type,
    input  logic [IDX_W-1:0]    s_point_index,
    input  logic [SEC_W-1:0]    s_source_seconds,
    input  logic [SEC_W-1:0]    s_target_seconds,
    input  logic [MS_W-1:0]     s_time_ms,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [MS_W-1:0]     m_mapped_ms,
    input  logic [STATUS_W-1:0] m_status,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [CNT_W-1:0]    cfg_point_count,
    output int                  fail_count,
    output int                  pending,
    output int                  checked,
    output bit [3:0]            status_seen
);

    typedef struct packed {
        logic [MS_W-1:0] mapped_ms;
        status_t         status;
    } mapped_word_t;

    logic [SEC_W-1:0] source_tab [MAX_POINTS_DEF];
    logic [SEC_W-1:0] target_tab [MAX_POINTS_DEF];
    logic [CNT_W-1:0] active_count;
    mapped_word_t     mapped_q [$];
    mapped_word_t     want;

    // Segment search plus floored interpolation, saturated to the millisecond range.
    function automatic mapped_word_t map_time(input logic [MS_W-1:0] t_ms);
        int           cnt;
        int           seg;
        longint       t, x1, x2, y1, y2, span, num, quo, sum;
        mapped_word_t r;
        cnt = active_count;
        if (cnt < 2) cnt = 2;
        if (cnt > MAX_POINTS_DEF) cnt = MAX_POINTS_DEF;
        t = t_ms;
        seg = 1;
        while (seg < cnt - 1) begin
            x2 = source_tab[seg];
            if (x2 * MS_PER_S >= t) break;
            seg++;
        end
        x1 = source_tab[seg-1];
        x2 = source_tab[seg];
        y1 = target_tab[seg-1];
        y2 = target_tab[seg];
        span = x2 - x1;
        if (span == 0) begin
            r.mapped_ms = '0;
            r.status    = STATUS_ZERO_WIDTH;
            return r;
        end
        num = (t - x1 * MS_PER_S) * (y2 - y1);
        quo = num / span;
        // round toward minus infinity, not toward zero
        if ((num % span != 0) && ((num < 0) != (span < 0))) quo--;
        sum = y1 * MS_PER_S + quo;
        if (sum < 0) begin
            r.mapped_ms = '0;
            r.status    = STATUS_LOW;
        end else if (sum > MAPPED_MAX) begin
            r.mapped_ms = MS_W'(MAPPED_MAX);
            r.status    = STATUS_HIGH;
        end else begin
            r.mapped_ms = MS_W'(sum);
            r.status    = STATUS_OK;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            active_count = CNT_W'(2);
            mapped_q.delete();
            fail_count   = 0;
            checked      = 0;
            status_seen  = '0;
            pending     <= 0;
        end else begin
            // retire the oldest expectation before queueing a new one
            if (m_valid && m_ready) begin
                if (mapped_q.size() == 0) begin
                    report_mismatch($sformatf("unrequested word: mapped_ms %0d status %0d",
                                              m_mapped_ms, m_status));
                end else begin
                    want = mapped_q.pop_front();
                    if (m_mapped_ms !== want.mapped_ms)
                        report_mismatch($sformatf("mapped_ms %0d, expected %0d",
                                                  m_mapped_ms, want.mapped_ms));
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_status, want.status));
                    checked++;
                    status_seen[m_status] = 1'b1;
                end
            end
            if (cfg_valid && cfg_ready) active_count = cfg_point_count;
            if (s_valid && s_ready) begin
                if (s_req_type == REQ_WRITE) begin
                    if (s_point_index < MAX_POINTS_DEF) begin
                        source_tab[s_point_index] = s_source_seconds;
                        target_tab[s_point_index] = s_target_seconds;
                    end
                end else begin
                    // append at the tail
                    mapped_q = {mapped_q, map_time(s_time_ms)};
                end
            end
            pending <= mapped_q.size();
        end
    end

endmodule

// ===== sim/tb_piecewise_linear_time_map.sv =====
// Stimulus and verdict for piecewise_linear_time_map: breakpoint tables, time stamps
// and point_count settings under several idling patterns. Depends on pltm_pkg, pltm_map_check.
`timescale 1ns / 1ps

module tb_piecewise_linear_time_map;
    import pltm_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASES        = 4;
    localparam int SETS_PER_PHASE = 5;
    localparam int MAPS_PER_SET  = 24;
    localparam int SEC_MAX       = 86399;

    localparam int DIR_SRC [16] = '{1000, 2000, 10000, 15000, 20000, 25000, 30000, 40000,
                                    60000, 45000, 65000, 70000, 75000, 80000, 86399, 86399};
    localparam int DIR_TGT [16] = '{0, 5000, 9000, 14000, 20000, 26000, 31000, 40000,
                                    61000, 46000, 65500, 70000, 74000, 80500, 86399, 0};

    logic                aclk             = 1'b0;
    logic                aresetn          = 1'b0;
    logic                s_valid          = 1'b0;
    logic                s_ready;
    logic                s_req_type       = 1'b0;
    logic [IDX_W-1:0]    s_point_index    = '0;
    logic [SEC_W-1:0]    s_source_seconds = '0;
    logic [SEC_W-1:0]    s_target_seconds = '0;
    logic [MS_W-1:0]     s_time_ms        = '0;
    logic                m_valid;
    logic                m_ready          = 1'b0;
    logic [MS_W-1:0]     m_mapped_ms;
    logic [STATUS_W-1:0] m_status;
    logic                cfg_valid        = 1'b0;
    logic                cfg_ready;
    logic [CNT_W-1:0]    cfg_point_count  = CNT_W'(2);

    int       fail_count;
    int       pending;
    int       checked;
    bit [3:0] status_seen;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int quiet_cycles = 0;
    int words_sent   = 0;
    int maps_sent    = 0;
    int settings_done = 0;
    int tb_src [16];

    always #HALF_PERIOD aclk = ~aclk;

    piecewise_linear_time_map dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_point_index    (s_point_index),
        .s_source_seconds (s_source_seconds),
        .s_target_seconds (s_target_seconds),
        .s_time_ms        (s_time_ms),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_mapped_ms      (m_mapped_ms),
        .m_status         (m_status),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_point_count  (cfg_point_count)
    );

    pltm_map_check map_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_point_index    (s_point_index),
        .s_source_seconds (s_source_seconds),
        .s_target_seconds (s_target_seconds),
        .s_time_ms        (s_time_ms),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_mapped_ms      (m_mapped_ms),
        .m_status         (m_status),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_point_count  (cfg_point_count),
        .fail_count       (fail_count),
        .pending          (pending),
        .checked          (checked),
        .status_seen      (status_seen)
    );

    wire any_accept = (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready);

    always @(posedge aclk) begin
        m_ready <= (int'($urandom_range(0, 99)) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || any_accept) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d words pending",
                     STALL_LIMIT, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int clamp_sec(input int v);
        if (v < 0) return 0;
        if (v > SEC_MAX) return SEC_MAX;
        return v;
    endfunction

    task automatic set_idling(input int tx, input int rx);
        tx_idle_pct   = tx;
        rx_stall_pct <= rx;
    endtask

    // Hold valid and payload until the word is taken.
    task automatic send_word(input req_t req, input logic [IDX_W-1:0] idx,
                             input logic [SEC_W-1:0] src, input logic [SEC_W-1:0] tgt,
                             input logic [MS_W-1:0] t_ms);
        while (int'($urandom_range(0, 99)) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_req_type       <= req;
        s_point_index    <= idx;
        s_source_seconds <= src;
        s_target_seconds <= tgt;
        s_time_ms        <= t_ms;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic send_point(input int idx, input int src, input int tgt);
        tb_src[idx] = src;
        send_word(REQ_WRITE, IDX_W'(idx), SEC_W'(src), SEC_W'(tgt),
                  MS_W'($urandom_range(0, MAPPED_MAX)));
    endtask

    task automatic send_map(input int t_ms);
        send_word(REQ_MAP, IDX_W'($urandom_range(0, 15)), SEC_W'($urandom_range(0, SEC_MAX)),
                  SEC_W'($urandom_range(0, SEC_MAX)), MS_W'(t_ms));
        maps_sent++;
    endtask

    // Drop valid, wait for every mapped word, then let a trailing write finish.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_point_count(input int v);
        settle();
        cfg_valid       <= 1'b1;
        cfg_point_count <= CNT_W'(v);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    // Mostly ascending tables; some with repeated sources, falling targets or no order.
    task automatic load_table(input int eff);
        int style, step_max, src, tgt, drift, k;
        style    = $urandom_range(0, 9);
        src      = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 40000));
        step_max = (SEC_MAX - src) / eff;
        if ($urandom_range(0, 1) == 1) step_max = step_max / 8 + 1;
        drift    = int'($urandom_range(0, 20000)) - 10000;
        tgt      = (style == 9) ? int'($urandom_range(40000, SEC_MAX)) : 0;
        for (k = 0; k < eff; k++) begin
            if (k > 0) begin
                // repeat a source now and then to build zero-width segments
                if (!(style == 7 && $urandom_range(0, 2) == 0))
                    src = clamp_sec(src + int'($urandom_range(1, step_max)));
            end
            if (style == 8) begin
                src = $urandom_range(0, SEC_MAX);
                tgt = $urandom_range(0, SEC_MAX);
            end else if (style == 9) begin
                tgt = clamp_sec(tgt - int'($urandom_range(0, 8000)));
            end else begin
                drift += int'($urandom_range(0, 2000)) - 1000;
                tgt = clamp_sec(src + drift);
            end
            send_point(k, src, tgt);
        end
    endtask

    function automatic int pick_time(input int eff);
        int r, j, hi, t;
        r = $urandom_range(0, 99);
        j = $urandom_range(0, eff - 1);
        if (r < 40) begin
            t = tb_src[j] * 1000 + int'($urandom_range(0, 4000)) - 2000;
        end else if (r < 70) begin
            hi = tb_src[eff-1] * 1000 + 5000000;
            if (hi > MAPPED_MAX) hi = MAPPED_MAX;
            t = $urandom_range(0, hi);
        end else if (r < 85) begin
            t = $urandom_range(0, MAPPED_MAX);
        end else begin
            case ($urandom_range(0, 2))
                0:       t = 0;
                1:       t = MAPPED_MAX;
                default: t = tb_src[j] * 1000;
            endcase
        end
        if (t < 0) t = 0;
        if (t > MAPPED_MAX) t = MAPPED_MAX;
        return t;
    endfunction

    initial begin : stimulus
        int k, p, n, m, v, eff;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        set_idling(0, 0);

        // fill every entry so no map ever reads an unwritten one
        for (k = 0; k < 16; k++) send_point(k, DIR_SRC[k], DIR_TGT[k]);
        // reset count of two: extrapolate below zero, above the maximum, interpolate
        send_map(0);
        send_map(MAPPED_MAX);
        send_map(1500000);
        // full table: last segment has zero width; time exactly on a breakpoint
        set_point_count(16);
        send_map(MAPPED_MAX);
        send_map(40000000);
        // ten points: last segment runs backward (unsorted table)
        set_point_count(10);
        send_map(MAPPED_MAX);
        // counts outside 2..16 act as the nearest limit
        set_point_count(0);
        send_map(123456789);
        set_point_count(31);
        send_map(86399000);
        set_point_count(17);
        send_map(70500000);

        for (p = 0; p < PHASES; p++) begin
            for (n = 0; n < SETS_PER_PHASE; n++) begin
                set_idling(0, 0);
                case ($urandom_range(0, 9))
                    0:       v = $urandom_range(0, 1);
                    1:       v = $urandom_range(17, 31);
                    2:       v = 16;
                    3:       v = 2;
                    4:       v = 31;
                    default: v = $urandom_range(2, 16);
                endcase
                set_point_count(v);
                eff = (v < 2) ? 2 : (v > 16) ? 16 : v;
                case (p)
                    0:       set_idling(0, 0);
                    1:       set_idling(87, 0);
                    2:       set_idling(0, 87);
                    default: set_idling(30, 30);
                endcase
                load_table(eff);
                for (m = 0; m < MAPS_PER_SET; m++) begin
                    // stray rewrites break the ordering now and then
                    if ($urandom_range(0, 99) < 8)
                        send_point($urandom_range(0, 15), $urandom_range(0, SEC_MAX),
                                   $urandom_range(0, SEC_MAX));
                    send_map(pick_time(eff));
                end
            end
        end

        settle();
        $display("drove %0d words (%0d time stamps, %0d breakpoint writes), %0d point_count settings",
                 words_sent, maps_sent, words_sent - maps_sent, settings_done);
        $display("checked %0d mapped words; status codes seen, one bit per code: %b",
                 checked, status_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
